@@ src/kcs_pkg.sv @@
package kcs_pkg;

  // Field and register widths.
  localparam int DELTA_W    = 24;
  localparam int NORM_W     = DELTA_W + 1;
  localparam int LIMIT_W    = 17;
  localparam int FRAC_W     = 16;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // The pair judge runs four products side by side.
  localparam int MUL_LANES = 4;

  // Register values after reset.
  localparam logic [DELTA_W-1:0] SHORT_RST   = DELTA_W'(52);
  localparam logic [DELTA_W-1:0] LONG_RST    = DELTA_W'(104);
  localparam logic [DELTA_W-1:0] SILENCE_RST = DELTA_W'(208);
  localparam logic [LIMIT_W-1:0] LIMIT_RST   = LIMIT_W'(22938);

  // Result symbol codes.
  typedef enum logic [1:0] {
    SYM_ZERO    = 2'd0,
    SYM_ONE     = 2'd1,
    SYM_SPACE   = 2'd2,
    SYM_UNKNOWN = 2'd3
  } kcs_sym_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT   = 2'd0,
    REG_LONG    = 2'd1,
    REG_SILENCE = 2'd2,
    REG_LIMIT   = 2'd3
  } kcs_reg_e;

endpackage

@@ src/kcs_ser_mul.sv @@
module kcs_ser_mul #(
  parameter int AW    = kcs_pkg::NORM_W,
  parameter int BW    = kcs_pkg::DELTA_W,
  parameter int LANES = kcs_pkg::MUL_LANES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [LANES-1:0][AW-1:0]       a_i,
  input  logic [LANES-1:0][BW-1:0]       b_i,
  output logic                           done_o,
  output logic [LANES-1:0][AW+BW-1:0]    prod_o
);

  localparam int CW = $clog2(BW + 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(BW - 1);

  logic                        busy_q;
  logic                        done_q;
  logic [CW-1:0]               cnt_q;
  logic [LANES-1:0][AW-1:0]    a_q;
  logic [LANES-1:0][AW+BW-1:0] p_q;
  logic [LANES-1:0][AW+BW-1:0] p_d;
  logic [LANES-1:0][AW:0]      sum_w;

  // One multiplier bit per cycle: add the multiplicand to the upper half and shift right.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sum_w[l] = {1'b0, p_q[l][AW+BW-1:BW]} + (p_q[l][0] ? {1'b0, a_q[l]} : '0);
      p_d[l]   = {sum_w[l], p_q[l][BW-1:1]};
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Product shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int l = 0; l < LANES; l++) begin
        a_q[l] <= a_i[l];
        p_q[l] <= {{AW{1'b0}}, b_i[l]};
      end
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

@@ src/kcs_ser_div.sv @@
module kcs_ser_div #(
  parameter int NW = kcs_pkg::NORM_W,
  parameter int DW = kcs_pkg::DELTA_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem_q;
  logic [NW-1:0] quo_q;
  logic [DW:0]   shifted_w;
  logic [DW:0]   diff_w;
  logic          ge_w;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    shifted_w = {rem_q, quo_q[NW-1]};
    diff_w    = shifted_w - {1'b0, den_q};
    ge_w      = shifted_w >= {1'b0, den_q};
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= ge_w ? diff_w[DW-1:0] : shifted_w[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge_w};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ src/kcs_half_period_classifier_unit.sv @@
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------------------
// in       | input     | in_valid_i / in_stall_o    | delta_ticks_i, end_of_stream_i
// out      | output    | out_valid_o / out_stall_i  | symbol_code_o, repeat_count_o,
//          |           |                            | last_of_run_o, *_total_o
// cfg      | input     | cfg_we_i                   | cfg_index_i, cfg_wdata_i
//
// An item that completes a pair is judged with the 24-step bit-serial multiplier.
// An item alone that is a space run is counted with the 25-step serial divider.
// A failed pair followed by a space run uses the multiplier, then the divider; a held item neither.
// One item is worked on at a time; the next is taken once the previous one's results are queued
// in the output register, so a stalled output only blocks once the next result is ready.
// Reset clears the held duration, the totals and the output valid; registers return to defaults.
module kcs_half_period_classifier_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kcs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [kcs_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [kcs_pkg::DELTA_W-1:0]       delta_ticks_i,
  input  logic                              end_of_stream_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        symbol_code_o,
  output logic [kcs_pkg::DELTA_W-1:0]       repeat_count_o,
  output logic                              last_of_run_o,
  output logic [kcs_pkg::CNT_W-1:0]         zero_total_o,
  output logic [kcs_pkg::CNT_W-1:0]         one_total_o,
  output logic [kcs_pkg::CNT_W-1:0]         space_total_o,
  output logic [kcs_pkg::CNT_W-1:0]         unknown_total_o
);

  import kcs_pkg::*;

  localparam int PROD_W = NORM_W + DELTA_W;
  localparam int LIM_W  = NORM_W + FRAC_W;
  localparam int LANE_ZS = 0;  // zero error times short target
  localparam int LANE_OL = 1;  // one error times long target
  localparam int LANE_LL = 2;  // limit times long target
  localparam int LANE_LS = 3;  // limit times short target
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ALONE,
    S_DIV,
    S_EMIT
  } state_e;

  function automatic logic [DELTA_W-1:0] abs_diff(logic [DELTA_W-1:0] a, logic [DELTA_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  state_e               state_q;
  logic [DELTA_W-1:0]   short_q;
  logic [DELTA_W-1:0]   long_q;
  logic [DELTA_W-1:0]   silence_q;
  logic [LIMIT_W-1:0]   limit_q;

  logic [DELTA_W-1:0]   held_q;
  logic                 held_valid_q;
  logic [DELTA_W-1:0]   d_q;
  logic                 eos_q;
  logic [NORM_W-1:0]    nz_q;
  logic [NORM_W-1:0]    no_q;

  kcs_sym_e             pend_code_q;
  logic [DELTA_W-1:0]   pend_rep_q;
  logic                 pend_last_q;
  logic                 after_alone_q;

  logic                 out_valid_q;
  kcs_sym_e             out_code_q;
  logic [DELTA_W-1:0]   out_rep_q;
  logic                 out_last_q;

  logic [CNT_W-1:0]     zero_cnt_q;
  logic [CNT_W-1:0]     one_cnt_q;
  logic [CNT_W-1:0]     space_cnt_q;
  logic [CNT_W-1:0]     unknown_cnt_q;

  logic                 in_accept;
  logic                 out_load;
  logic [NORM_W-1:0]    nz_w;
  logic [NORM_W-1:0]    no_w;
  logic [DELTA_W-1:0]   sil_thr_w;
  logic                 sil_w;
  logic [NORM_W-1:0]    div_num_w;
  logic [DELTA_W-1:0]   space_rep_w;
  logic                 z_le_o_w;
  logic                 z_ok_w;
  logic                 o_ok_w;
  kcs_sym_e             pair_code_w;
  logic [CNT_W:0]       space_sum_w;

  logic                               mul_done;
  logic [MUL_LANES-1:0][NORM_W-1:0]   mul_a;
  logic [MUL_LANES-1:0][DELTA_W-1:0]  mul_b;
  logic [MUL_LANES-1:0][PROD_W-1:0]   mul_p;
  logic                               div_start;
  logic                               div_done;
  logic [NORM_W-1:0]                  div_quo;

  // Handshakes.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  // Pair distances from both targets, formed as the second duration arrives.
  always_comb begin
    nz_w = {1'b0, abs_diff(held_q, long_q)} + {1'b0, abs_diff(delta_ticks_i, long_q)};
    no_w = {1'b0, abs_diff(held_q, short_q)} + {1'b0, abs_diff(delta_ticks_i, short_q)};
    mul_a[LANE_ZS] = nz_w;
    mul_a[LANE_OL] = no_w;
    mul_a[LANE_LL] = {{(NORM_W-LIMIT_W){1'b0}}, limit_q};
    mul_a[LANE_LS] = {{(NORM_W-LIMIT_W){1'b0}}, limit_q};
    mul_b[LANE_ZS] = short_q;
    mul_b[LANE_OL] = long_q;
    mul_b[LANE_LL] = long_q;
    mul_b[LANE_LS] = short_q;
  end

  // Pair decision from the finished products; a zero target never wins.
  always_comb begin
    if (long_q == '0) begin
      z_le_o_w = (short_q == '0);
    end else if (short_q == '0) begin
      z_le_o_w = 1'b1;
    end else begin
      z_le_o_w = mul_p[LANE_ZS] <= mul_p[LANE_OL];
    end
    z_ok_w = (long_q != '0) &&
             ({1'b0, nz_q, {FRAC_W{1'b0}}} <= {mul_p[LANE_LL][LIM_W-1:0], 1'b0});
    o_ok_w = (short_q != '0) &&
             ({1'b0, no_q, {FRAC_W{1'b0}}} <= {mul_p[LANE_LS][LIM_W-1:0], 1'b0});
    if (z_le_o_w && z_ok_w) begin
      pair_code_w = SYM_ZERO;
    end else if (!z_le_o_w && o_ok_w) begin
      pair_code_w = SYM_ONE;
    end else begin
      pair_code_w = SYM_UNKNOWN;
    end
  end

  // Silence test and rounded space count of the current duration.
  always_comb begin
    sil_thr_w   = silence_q - {2'b00, silence_q[DELTA_W-1:2]};
    sil_w       = (silence_q != '0) && (d_q >= sil_thr_w);
    div_num_w   = {1'b0, d_q} + {2'b00, silence_q[DELTA_W-1:1]};
    space_rep_w = (div_quo[DELTA_W-1:0] == '0) ? DELTA_W'(1) : div_quo[DELTA_W-1:0];
    space_sum_w = {1'b0, space_cnt_q} + {{(CNT_W+1-DELTA_W){1'b0}}, pend_rep_q};
  end

  assign div_start = (state_q == S_ALONE) && sil_w;

  kcs_ser_mul #(
    .AW    (NORM_W),
    .BW    (DELTA_W),
    .LANES (MUL_LANES)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept && held_valid_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  kcs_ser_div #(
    .NW (NORM_W),
    .DW (DELTA_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num_w),
    .den_i   (silence_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q   <= SHORT_RST;
      long_q    <= LONG_RST;
      silence_q <= SILENCE_RST;
      limit_q   <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SHORT:   short_q   <= cfg_wdata_i[DELTA_W-1:0];
        REG_LONG:    long_q    <= cfg_wdata_i[DELTA_W-1:0];
        REG_SILENCE: silence_q <= cfg_wdata_i[DELTA_W-1:0];
        REG_LIMIT:   limit_q   <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, held duration, output register and totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      held_q        <= '0;
      held_valid_q  <= 1'b0;
      d_q           <= '0;
      eos_q         <= 1'b0;
      nz_q          <= '0;
      no_q          <= '0;
      pend_code_q   <= SYM_ZERO;
      pend_rep_q    <= '0;
      pend_last_q   <= 1'b0;
      after_alone_q <= 1'b0;
      out_valid_q   <= 1'b0;
      out_code_q    <= SYM_ZERO;
      out_rep_q     <= '0;
      out_last_q    <= 1'b0;
      zero_cnt_q    <= '0;
      one_cnt_q     <= '0;
      space_cnt_q   <= '0;
      unknown_cnt_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            d_q   <= delta_ticks_i;
            eos_q <= end_of_stream_i;
            if (held_valid_q) begin
              nz_q         <= nz_w;
              no_q         <= no_w;
              held_valid_q <= 1'b0;
              state_q      <= S_MUL;
            end else begin
              state_q <= S_ALONE;
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            pend_rep_q <= DELTA_W'(1);
            if (pair_code_w != SYM_UNKNOWN) begin
              pend_code_q   <= pair_code_w;
              pend_last_q   <= 1'b1;
              after_alone_q <= 1'b0;
            end else begin
              // The second duration is judged again on its own.
              pend_code_q   <= SYM_UNKNOWN;
              pend_last_q   <= !(sil_w || eos_q);
              after_alone_q <= 1'b1;
            end
            state_q <= S_EMIT;
          end
        end
        S_ALONE: begin
          if (sil_w) begin
            state_q <= S_DIV;
          end else if (eos_q) begin
            pend_code_q   <= SYM_UNKNOWN;
            pend_rep_q    <= DELTA_W'(1);
            pend_last_q   <= 1'b1;
            after_alone_q <= 1'b0;
            state_q       <= S_EMIT;
          end else begin
            held_q       <= d_q;
            held_valid_q <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            pend_code_q   <= SYM_SPACE;
            pend_rep_q    <= space_rep_w;
            pend_last_q   <= 1'b1;
            after_alone_q <= 1'b0;
            state_q       <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_code_q  <= pend_code_q;
            out_rep_q   <= pend_rep_q;
            out_last_q  <= pend_last_q;
            case (pend_code_q)
              SYM_ZERO: begin
                if (zero_cnt_q != CNT_MAX) zero_cnt_q <= zero_cnt_q + CNT_W'(1);
              end
              SYM_ONE: begin
                if (one_cnt_q != CNT_MAX) one_cnt_q <= one_cnt_q + CNT_W'(1);
              end
              SYM_SPACE: begin
                space_cnt_q <= space_sum_w[CNT_W] ? CNT_MAX : space_sum_w[CNT_W-1:0];
              end
              default: begin
                if (unknown_cnt_q != CNT_MAX) unknown_cnt_q <= unknown_cnt_q + CNT_W'(1);
              end
            endcase
            state_q <= after_alone_q ? S_ALONE : S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The totals shown belong to the item in the output register.
  assign out_valid_o     = out_valid_q;
  assign symbol_code_o   = out_code_q;
  assign repeat_count_o  = out_rep_q;
  assign last_of_run_o   = out_last_q;
  assign zero_total_o    = zero_cnt_q;
  assign one_total_o     = one_cnt_q;
  assign space_total_o   = space_cnt_q;
  assign unknown_total_o = unknown_cnt_q;

  // Serial units finish only while the sequencer waits for them.
  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_MUL)
    else $error("multiplier finished outside the pair state");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the space state");

  // Totals move only when an item is loaded into the output register.
  a_totals_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_load |=> $stable(zero_cnt_q) && $stable(one_cnt_q) &&
                  $stable(space_cnt_q) && $stable(unknown_cnt_q))
    else $error("totals changed without a result");

  // A space run counts at least one space; every other symbol counts one.
  a_repeat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (symbol_code_o == SYM_SPACE) ? (repeat_count_o != '0)
                                                  : (repeat_count_o == DELTA_W'(1)))
    else $error("repeat count out of range");

endmodule
